@@ src/gha_pkg.sv @@
`timescale 1ns / 1ps

package gha_pkg;

  localparam int MaxDim  = 16;
  localparam int DimW    = $clog2(MaxDim);
  localparam int IdxW    = $clog2(MaxDim + 1);
  localparam int CntW    = $clog2(MaxDim * MaxDim + 1);
  localparam int AddrW   = 2 * DimW;
  localparam int CostW   = 16;
  localparam int GateW   = 17;
  localparam int PotW    = 24;
  localparam int RegAdrW = 4;

  localparam logic signed [PotW-1:0] SlackTop = {1'b0, {(PotW-1){1'b1}}};
  localparam logic [GateW-1:0]       OneQ88   = GateW'(256);

  localparam logic [1:0] RegRowCount = 2'd0;
  localparam logic [1:0] RegColCount = 2'd1;
  localparam logic [1:0] RegMaxCost  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_AUG,
    ST_ROW,
    ST_SCAN,
    ST_UPD,
    ST_BACK,
    ST_OCLR,
    ST_ORD,
    ST_OCHK,
    ST_EMIT
  } state_e;

endpackage

@@ src/gated_hungarian_assignment.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                        Direction
// in        in_valid_i / in_ready_o: cost_i usable_i last_i   sink
// out       out_valid_o / out_ready_i: row_o col_o matched_o final_res_o  source
// config    psel penable pwrite paddr pwdata prdata pready    APB slave
//
// Loading takes one cycle per item; in_ready_o stays high until the last item.
// The solve runs on one shared subtract-compare unit, one column per cycle:
// each search step of a row scans every column, then updates the potentials
// and slacks of every column; after the solve the owners are checked column
// by column, then one result per cycle as taken.
// Reset idles control and sets configuration to its maxima; the cost memory
// is undefined until loaded. A stalled output holds its register; no new item
// is taken until every result of the current matrix has been loaded into it.
module gated_hungarian_assignment
  import gha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CostW-1:0]   cost_i,
  input  logic               usable_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DimW-1:0]    row_o,
  output logic [DimW-1:0]    col_o,
  output logic               matched_o,
  output logic               final_res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [RegAdrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers, held already clamped to their legal range
  logic [IdxW-1:0]  rows_q, cols_q;
  logic [CostW-1:0] maxc_q;
  logic             cfg_wr;
  logic [IdxW-1:0]  dim_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    if (pwdata[IdxW-1:0] == '0) begin
      dim_wr = IdxW'(1);
    end else if (pwdata[IdxW-1:0] > IdxW'(MaxDim)) begin
      dim_wr = IdxW'(MaxDim);
    end else begin
      dim_wr = pwdata[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= IdxW'(MaxDim);
      cols_q <= IdxW'(MaxDim);
      maxc_q <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegRowCount: rows_q <= dim_wr;
        RegColCount: cols_q <= dim_wr;
        RegMaxCost:  maxc_q <= (pwdata[CostW-1:0] == '0) ? CostW'(1) : pwdata[CostW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRowCount: prdata = 32'(rows_q);
      RegColCount: prdata = 32'(cols_q);
      RegMaxCost:  prdata = 32'(maxc_q);
      default:     prdata = '0;
    endcase
  end

  // Derived sizes
  logic [IdxW-1:0] n;
  logic [CntW-1:0] total;
  assign n     = (rows_q > cols_q) ? rows_q : cols_q;
  assign total = CntW'(rows_q) * CntW'(cols_q);

  // Cost memory, gated entries at {row, col}
  logic [GateW-1:0] cost_mem [MaxDim*MaxDim];
  logic [GateW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;
  logic [GateW-1:0] gated;

  // Solver state
  state_e                 state_q, state_d;
  logic [IdxW-1:0]        i_q, i_d, j_q, j_d, j0_q, j0_d, j1_q, j1_d;
  logic [IdxW-1:0]        i0_q, i0_d, guard_q, guard_d, r_q, r_d;
  logic signed [PotW-1:0] ui0_q, ui0_d, delta_q, delta_d;
  logic [CntW-1:0]        ld_cnt_q, ld_cnt_d;
  logic [DimW-1:0]        ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic                   ov_q, ov_d;
  logic [DimW-1:0]        row_q, row_d, col_q, col_d;
  logic                   mat_q, mat_d, fin_q, fin_d;

  logic signed [PotW-1:0] u_q    [MaxDim+1];
  logic signed [PotW-1:0] v_q    [MaxDim+1];
  logic signed [PotW-1:0] minv_q [MaxDim+1];
  logic [IdxW-1:0]        p_q    [MaxDim+1];
  logic [IdxW-1:0]        way_q  [MaxDim+1];
  logic [MaxDim:0]        used_q;
  logic [DimW-1:0]        asg_q  [MaxDim];
  logic [MaxDim-1:0]      ok_q;

  logic                   in_acc;
  logic [IdxW-1:0]        i0_row, i0m1, jm1, pj, pjm1;
  logic [GateW-1:0]       ent;
  logic signed [PotW-1:0] cur, mv;
  logic                   take, own_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = ov_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign matched_o   = mat_q;
  assign final_res_o = fin_q;

  assign gated  = (usable_i && (cost_i <= maxc_q)) ? {1'b0, cost_i}
                                                   : ({1'b0, maxc_q} + OneQ88);
  assign mem_we = in_acc && (ld_cnt_q < total);

  // Shared datapath: one column slack per cycle
  assign i0_row = p_q[j0_q];
  assign i0m1   = i0_q - IdxW'(1);
  assign jm1    = j_q - IdxW'(1);
  assign pj     = p_q[j_q];
  assign pjm1   = pj - IdxW'(1);
  assign ent    = ((i0_q > rows_q) || (j_q > cols_q)) ? {1'b0, maxc_q} : rd_q;
  assign cur    = $signed(PotW'(ent)) - ui0_q - v_q[j_q];
  assign mv     = (cur < minv_q[j_q]) ? cur : minv_q[j_q];
  assign take   = !used_q[j_q] && (mv < delta_q);
  assign own_ok = (pj != '0) && (pj <= rows_q) && (j_q <= cols_q) &&
                  (rd_q <= {1'b0, maxc_q});

  always_comb begin
    unique case (state_q)
      ST_ROW: begin
        rd_addr = {i0_row[DimW-1:0] - DimW'(1), DimW'(0)};
      end
      ST_SCAN: rd_addr = {i0m1[DimW-1:0], j_q[DimW-1:0]};
      ST_ORD:  rd_addr = {pjm1[DimW-1:0], jm1[DimW-1:0]};
      default: rd_addr = {ld_row_q, ld_col_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cost_mem[{ld_row_q, ld_col_q}] <= gated;
    end
    rd_q <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ld_cnt_q <= '0;
      ld_row_q <= '0;
      ld_col_q <= '0;
      ov_q     <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      j0_q     <= '0;
      j1_q     <= '0;
      i0_q     <= '0;
      guard_q  <= '0;
      r_q      <= '0;
    end else begin
      state_q  <= state_d;
      ld_cnt_q <= ld_cnt_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      ov_q     <= ov_d;
      i_q      <= i_d;
      j_q      <= j_d;
      j0_q     <= j0_d;
      j1_q     <= j1_d;
      i0_q     <= i0_d;
      guard_q  <= guard_d;
      r_q      <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ui0_q   <= ui0_d;
    delta_q <= delta_d;
    row_q   <= row_d;
    col_q   <= col_d;
    mat_q   <= mat_d;
    fin_q   <= fin_d;
  end

  // Next state and sequencer counters
  always_comb begin
    state_d  = state_q;
    ld_cnt_d = ld_cnt_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    ov_d     = ov_q;
    i_d      = i_q;
    j_d      = j_q;
    j0_d     = j0_q;
    j1_d     = j1_q;
    i0_d     = i0_q;
    guard_d  = guard_q;
    r_d      = r_q;
    ui0_d    = ui0_q;
    delta_d  = delta_q;
    row_d    = row_q;
    col_d    = col_q;
    mat_d    = mat_q;
    fin_d    = fin_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mem_we) begin
            ld_cnt_d = ld_cnt_q + CntW'(1);
            if (IdxW'(ld_col_q) + IdxW'(1) >= cols_q) begin
              ld_col_d = '0;
              ld_row_d = ld_row_q + DimW'(1);
            end else begin
              ld_col_d = ld_col_q + DimW'(1);
            end
          end
          if (last_i) begin
            ld_cnt_d = '0;
            ld_row_d = '0;
            ld_col_d = '0;
            state_d  = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        i_d     = IdxW'(1);
        state_d = ST_AUG;
      end
      ST_AUG: begin
        j0_d    = '0;
        guard_d = '0;
        state_d = ST_ROW;
      end
      ST_ROW: begin
        i0_d    = i0_row;
        ui0_d   = u_q[i0_row];
        delta_d = SlackTop;
        j1_d    = '0;
        j_d     = IdxW'(1);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (take) begin
          delta_d = mv;
          j1_d    = j_q;
        end
        if (j_q == n) begin
          j_d = '0;
          if (take || (j1_q != '0)) begin
            state_d = ST_UPD;
          end else begin
            guard_d = '0;
            state_d = ST_BACK;
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_UPD: begin
        if (j_q == n) begin
          j0_d = j1_q;
          if ((p_q[j1_q] != '0) && (guard_q + IdxW'(1) <= n)) begin
            guard_d = guard_q + IdxW'(1);
            state_d = ST_ROW;
          end else begin
            guard_d = '0;
            state_d = ST_BACK;
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_BACK: begin
        if ((j0_q != '0) && (guard_q <= n)) begin
          j0_d    = way_q[j0_q];
          guard_d = guard_q + IdxW'(1);
        end else if (i_q == n) begin
          state_d = ST_OCLR;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_AUG;
        end
      end
      ST_OCLR: begin
        j_d     = IdxW'(1);
        state_d = ST_ORD;
      end
      ST_ORD: begin
        state_d = ST_OCHK;
      end
      ST_OCHK: begin
        if (j_q == n) begin
          r_d     = '0;
          state_d = ST_EMIT;
        end else begin
          j_d     = j_q + IdxW'(1);
          state_d = ST_ORD;
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          if (r_q < rows_q) begin
            ov_d  = 1'b1;
            row_d = r_q[DimW-1:0];
            mat_d = ok_q[r_q[DimW-1:0]];
            col_d = ok_q[r_q[DimW-1:0]] ? asg_q[r_q[DimW-1:0]] : '0;
            fin_d = (r_q + IdxW'(1) == rows_q);
            r_d   = r_q + IdxW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Solver arrays: potentials, owners, links, slacks and visit marks
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_INIT: begin
        for (int k = 0; k <= MaxDim; k++) begin
          u_q[k]   <= '0;
          v_q[k]   <= '0;
          p_q[k]   <= '0;
          way_q[k] <= '0;
        end
      end
      ST_AUG: begin
        p_q[0] <= i_q;
        used_q <= '0;
        for (int k = 0; k <= MaxDim; k++) begin
          minv_q[k] <= SlackTop;
        end
      end
      ST_ROW: begin
        used_q[j0_q] <= 1'b1;
      end
      ST_SCAN: begin
        if (!used_q[j_q] && (cur < minv_q[j_q])) begin
          minv_q[j_q] <= cur;
          way_q[j_q]  <= j0_q;
        end
      end
      ST_UPD: begin
        if (used_q[j_q]) begin
          u_q[pj]  <= u_q[pj] + delta_q;
          v_q[j_q] <= v_q[j_q] - delta_q;
        end else begin
          minv_q[j_q] <= minv_q[j_q] - delta_q;
        end
      end
      ST_BACK: begin
        if ((j0_q != '0) && (guard_q <= n)) begin
          p_q[j0_q] <= p_q[way_q[j0_q]];
        end
      end
      default: ;
    endcase
  end

  // Per-row result table
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OCLR) begin
      ok_q <= '0;
    end else if ((state_q == ST_OCHK) && own_ok) begin
      ok_q[pjm1[DimW-1:0]]  <= 1'b1;
      asg_q[pjm1[DimW-1:0]] <= jm1[DimW-1:0];
    end
  end

endmodule
